// ===== hw/rtl/bgd_pkg.sv =====
package bgd_pkg;

  // Tick counter width; elapsed time wraps modulo 2^TICK_W
  localparam int TICK_W = 32;

  localparam int NOW_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int EVENT_W = 3;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] CLICK_RST = 16'd300;
  localparam logic [CFG_W-1:0] RELEASE_RST = 16'd300;
  localparam logic [CFG_W-1:0] HOLD_RST = 16'd3000;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd2;
  localparam logic [EVENT_W-1:0] EV_HOLD = 3'd3;
  localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd4;
  localparam logic [EVENT_W-1:0] EV_ERROR = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_DEB_PRESS   = 4'd1,
    ST_FIRST_PRESS = 4'd2,
    ST_GAP         = 4'd3,
    ST_EMIT_SINGLE = 4'd4,
    ST_DEB_SECOND  = 4'd5,
    ST_SECOND      = 4'd6,
    ST_EMIT_DOUBLE = 4'd7,
    ST_WAIT_HOLD   = 4'd8,
    ST_HOLDING     = 4'd9,
    ST_WAIT_REL    = 4'd10,
    ST_EMIT_REL    = 4'd11,
    ST_EMIT_ERR    = 4'd12
  } gest_state_t;

endpackage

// ===== hw/rtl/button_gesture_detector.sv =====
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------
// in        | in_valid / in_stall  | in_pin_level, in_now_tick
// out       | out_valid / out_stall| out_event_code
// cfg       | cfg_we               | cfg_index, cfg_wdata
//
// One poll per cycle: the state machine advances at the transfer edge and the
// held event lands in the output register; it is offered the cycle after.
// The single output register sets the rate; in_stall rises only while a result
// waits there under out_stall, and a poll is taken in the cycle it drains.
// Synchronous active-low reset returns the machine to idle with no event and
// loads the default thresholds.
module button_gesture_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pin_level,
  input  logic [bgd_pkg::NOW_W-1:0]     in_now_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bgd_pkg::EVENT_W-1:0]   out_event_code,
  input  logic                          cfg_we,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgd_pkg::CFG_W-1:0]     cfg_wdata
);
  import bgd_pkg::*;

  logic [CFG_W-1:0]   debounce_r, click_r, release_r, hold_r;
  gest_state_t        state_r, state_nxt;
  logic [TICK_W-1:0]  start_r, start_nxt;
  logic [EVENT_W-1:0] held_r, held_nxt;
  logic               out_valid_r;
  logic [EVENT_W-1:0] out_event_r;

  logic               in_xfer;
  logic [TICK_W-1:0]  now;
  logic [TICK_W-1:0]  elapsed;
  logic               deb_done, click_lt, rel_lt, rel_le, hold_le;

  // Handshake: take a poll unless a result is stuck in the output register
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // Elapsed ticks and threshold compares
  assign now      = TICK_W'(in_now_tick);
  assign elapsed  = now - start_r;
  assign deb_done = elapsed >= TICK_W'(debounce_r);
  assign click_lt = elapsed <  TICK_W'(click_r);
  assign rel_lt   = elapsed <  TICK_W'(release_r);
  assign rel_le   = elapsed <= TICK_W'(release_r);
  assign hold_le  = elapsed <= TICK_W'(hold_r);

  // Next state and start tick
  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_pin_level) begin
          state_nxt = ST_DEB_PRESS;
          start_nxt = now;
        end
      end
      ST_DEB_PRESS: begin
        if (deb_done) begin
          if (!in_pin_level) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FIRST_PRESS;
            start_nxt = now;
          end
        end
      end
      ST_FIRST_PRESS: begin
        priority if (!in_pin_level && click_lt) begin
          state_nxt = ST_GAP;
          start_nxt = now;
        end else if (!click_lt) begin
          state_nxt = ST_WAIT_HOLD;
        end else begin
          state_nxt = state_r;
        end
      end
      ST_GAP: begin
        priority if (!in_pin_level && !rel_lt) begin
          state_nxt = ST_EMIT_SINGLE;
        end else if (in_pin_level && rel_lt) begin
          state_nxt = ST_DEB_SECOND;
          start_nxt = now;
        end else begin
          state_nxt = state_r;
        end
      end
      ST_EMIT_SINGLE: state_nxt = ST_IDLE;
      ST_DEB_SECOND: begin
        if (deb_done) begin
          if (!in_pin_level) begin
            state_nxt = ST_EMIT_SINGLE;
          end else begin
            state_nxt = ST_SECOND;
            start_nxt = now;
          end
        end
      end
      ST_SECOND: begin
        // late release stays here until the next press, which ends as an error
        priority if (!in_pin_level && click_lt) begin
          state_nxt = ST_EMIT_DOUBLE;
        end else if (in_pin_level && !click_lt) begin
          state_nxt = ST_EMIT_ERR;
        end else begin
          state_nxt = state_r;
        end
      end
      ST_EMIT_DOUBLE: state_nxt = ST_IDLE;
      ST_WAIT_HOLD: begin
        priority if (!in_pin_level && hold_le) begin
          state_nxt = ST_EMIT_ERR;
        end else if (!hold_le) begin
          state_nxt = ST_HOLDING;
        end else begin
          state_nxt = state_r;
        end
      end
      ST_HOLDING: begin
        if (!in_pin_level) begin
          state_nxt = ST_WAIT_REL;
          start_nxt = now;
        end
      end
      ST_WAIT_REL: begin
        priority if (in_pin_level && rel_le) begin
          state_nxt = ST_HOLDING;
        end else if (!rel_le) begin
          state_nxt = ST_EMIT_REL;
        end else begin
          state_nxt = state_r;
        end
      end
      ST_EMIT_REL: state_nxt = ST_IDLE;
      ST_EMIT_ERR: state_nxt = ST_IDLE;
      default: state_nxt = state_r;
    endcase
  end

  // Held event update
  always_comb begin
    held_nxt = held_r;
    unique case (state_r)
      ST_IDLE:        held_nxt = EV_NONE;
      ST_EMIT_SINGLE: held_nxt = EV_SINGLE;
      ST_EMIT_DOUBLE: held_nxt = EV_DOUBLE;
      ST_HOLDING:     held_nxt = EV_HOLD;
      ST_EMIT_REL:    held_nxt = EV_RELEASE;
      ST_EMIT_ERR:    held_nxt = EV_ERROR;
      default:        held_nxt = held_r;
    endcase
  end

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      click_r    <= CLICK_RST;
      release_r  <= RELEASE_RST;
      hold_r     <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata;
        CFG_CLICK:    click_r    <= cfg_wdata;
        CFG_RELEASE:  release_r  <= cfg_wdata;
        CFG_HOLD:     hold_r     <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Machine state, advanced once per input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= '0;
      held_r  <= EV_NONE;
    end else if (in_xfer) begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      held_r  <= held_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_event_r <= held_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;

endmodule

// ===== hw/rtl/bgd_checker.sv =====
module bgd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bgd_pkg::EVENT_W-1:0]   out_event_code
);
  import bgd_pkg::*;

  // Input is only held off by a stuck result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // Every poll gives a result next cycle
  a_poll_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("poll transfer produced no result");

  // No result without a poll
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !(in_valid && !in_stall)) |=> !out_valid)
    else $error("result appeared without a poll");

  // Event code stays in its range
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_code <= EV_ERROR))
    else $error("event code out of range");

  // Stalled result holds valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("out_valid dropped under stall");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code)
);
